/* hdl/strict_base64_decoder_defines.svh */
// assertion macros for the strict base64 decoder
// used by the top level only, no other dependencies
`ifndef STRICT_BASE64_DECODER_DEFINES_SVH
`define STRICT_BASE64_DECODER_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define SB64_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sb64 check failed");

// next-cycle implication, disabled while reset is held
`define SB64_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sb64 check failed");

`endif

/* hdl/sb64_pkg.sv */
// shared types, status codes and alphabet lookup for the base64 decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sb64_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // message status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_LENGTH = 3'd1,
    ST_BAD_PAD    = 3'd2,
    ST_BAD_CHAR   = 3'd3,
    ST_NONCANON   = 3'd4
  } status_e;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } sextet_t;

  // results caused by one input word: up to three bytes, then an optional status
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            fin;
    status_e         status;
  } bundle_t;

  // standard alphabet lookup, invalid characters read as sextet zero
  function automatic sextet_t sextet_of(logic [7:0] c);
    sextet_t r;
    r.ok    = 1'b1;
    r.value = '0;
    case (c) inside
      [8'h41:8'h5A]: r.value = 6'(c - 8'h41);
      [8'h61:8'h7A]: r.value = 6'(c - 8'h61 + 8'd26);
      [8'h30:8'h39]: r.value = 6'(c - 8'h30 + 8'd52);
      8'h2B:         r.value = 6'd62;
      8'h2F:         r.value = 6'd63;
      default:       r.ok    = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/sb64_group.sv */
// group assembly: per-character decode, strict padding rules and error tracking
// depends on sb64_pkg
`timescale 1ns / 1ps
`default_nettype none

module sb64_group (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire logic [7:0]      char_code_i,
  input  wire logic            is_final_i,
  output sb64_pkg::bundle_t    bundle_o,
  output logic                 has_results_o,
  output logic [1:0]           quad_o
);

  logic [23:0]       group_q, group_d;
  logic [1:0]        quad_q, quad_d;
  logic [1:0]        pad_q, pad_d;
  sb64_pkg::status_e ferr_q, ferr_d;

  sb64_pkg::sextet_t sx;
  sb64_pkg::status_e err;
  sb64_pkg::status_e ferr_n;
  logic              is_pad;
  logic [5:0]        sextet;
  logic [1:0]        pad_n;
  logic [23:0]       group_n;

  assign sx     = sb64_pkg::sextet_of(char_code_i);
  assign is_pad = (char_code_i == sb64_pkg::PAD_CHAR);

  // classify the character at its place in the group
  always_comb begin
    err    = sb64_pkg::ST_OK;
    sextet = '0;
    pad_n  = pad_q;
    case (quad_q)
      2'd0, 2'd1: begin
        if (is_pad) err = sb64_pkg::ST_BAD_PAD;
        else if (!sx.ok) err = sb64_pkg::ST_BAD_CHAR;
        else sextet = sx.value;
      end
      2'd2: begin
        if (is_pad) pad_n = 2'd1;
        else if (!sx.ok) err = sb64_pkg::ST_BAD_CHAR;
        else sextet = sx.value;
      end
      default: begin
        if (pad_q == 2'd1) begin
          if (!is_pad || !is_final_i) err = sb64_pkg::ST_BAD_PAD;
          else pad_n = 2'd2;
        end else if (is_pad) begin
          if (!is_final_i) err = sb64_pkg::ST_BAD_PAD;
          else pad_n = 2'd1;
        end else if (!sx.ok) begin
          err = sb64_pkg::ST_BAD_CHAR;
        end else begin
          sextet = sx.value;
        end
      end
    endcase
    group_n = {group_q[17:0], sextet};
    // trailing bits under padding must be zero
    if (quad_q == 2'd3 && err == sb64_pkg::ST_OK) begin
      if ((pad_n == 2'd1 && group_n[7:0] != 8'h00) ||
          (pad_n == 2'd2 && group_n[15:0] != 16'h0000)) begin
        err = sb64_pkg::ST_NONCANON;
      end
    end
    ferr_n = (err != sb64_pkg::ST_OK && ferr_q == sb64_pkg::ST_OK) ? err : ferr_q;
  end

  // bytes of a completed group and the closing status
  always_comb begin
    bundle_o.bytes  = group_n;
    bundle_o.nbytes = 2'd0;
    if (quad_q == 2'd3 && ferr_n == sb64_pkg::ST_OK) begin
      bundle_o.nbytes = 2'd3 - pad_n;
    end
    bundle_o.fin    = is_final_i;
    bundle_o.status = (quad_q != 2'd3) ? sb64_pkg::ST_BAD_LENGTH : ferr_n;
    bundle_o.bytes  = {group_n[23:16], group_n[15:8], group_n[7:0]};
  end

  assign has_results_o = (bundle_o.nbytes != 2'd0) || is_final_i;

  // next state: restart on the final word, clear group data at group end
  always_comb begin
    group_d = group_q;
    quad_d  = quad_q;
    pad_d   = pad_q;
    ferr_d  = ferr_q;
    if (fire_i) begin
      if (is_final_i) begin
        group_d = '0;
        quad_d  = '0;
        pad_d   = '0;
        ferr_d  = sb64_pkg::ST_OK;
      end else if (quad_q == 2'd3) begin
        group_d = '0;
        quad_d  = '0;
        pad_d   = '0;
        ferr_d  = ferr_n;
      end else begin
        group_d = group_n;
        quad_d  = quad_q + 2'd1;
        pad_d   = pad_n;
        ferr_d  = ferr_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
      quad_q  <= '0;
      pad_q   <= '0;
      ferr_q  <= sb64_pkg::ST_OK;
    end else begin
      group_q <= group_d;
      quad_q  <= quad_d;
      pad_q   <= pad_d;
      ferr_q  <= ferr_d;
    end
  end

  assign quad_o = quad_q;

endmodule

`default_nettype wire

/* hdl/sb64_emit.sv */
// result register and sequencer: sends the bytes and status of one word in order
// depends on sb64_pkg
`timescale 1ns / 1ps
`default_nettype none

module sb64_emit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire sb64_pkg::bundle_t bundle_i,
  output logic                   space_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic [2:0]             status_o,
  output logic                   run_end_o,
  output logic                   message_end_o
);

  sb64_pkg::bundle_t bundle_q;
  logic              full_q;
  logic [1:0]        idx_q;
  logic [2:0]        total;
  logic              is_byte;
  logic              last;
  logic              out_fire;

  // position of the current result within the bundle
  assign total    = {1'b0, bundle_q.nbytes} + {2'b00, bundle_q.fin};
  assign last     = ({1'b0, idx_q} == total - 3'd1);
  assign is_byte  = (idx_q < bundle_q.nbytes);
  assign out_fire = full_q && out_ready_i;

  // the register frees up as its last result is taken
  assign space_o = !full_q || (out_ready_i && last);

  // result fields
  always_comb begin
    out_byte_o = 8'h00;
    if (is_byte) begin
      case (idx_q)
        2'd0:    out_byte_o = bundle_q.bytes[2];
        2'd1:    out_byte_o = bundle_q.bytes[1];
        2'd2:    out_byte_o = bundle_q.bytes[0];
        default: out_byte_o = 8'h00;
      endcase
    end
  end

  assign status_o      = is_byte ? sb64_pkg::ST_OK : bundle_q.status;
  assign message_end_o = !is_byte;
  assign run_end_o     = last;
  assign out_valid_o   = full_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      full_q <= 1'b1;
      idx_q  <= '0;
    end else if (out_fire && last) begin
      full_q <= 1'b0;
      idx_q  <= '0;
    end else if (out_fire) begin
      idx_q  <= idx_q + 2'd1;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bundle_q <= bundle_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/strict_base64_decoder.sv */
// strict base64 decoder top level: character input, byte and status output
// depends on sb64_pkg, sb64_group, sb64_emit and strict_base64_decoder_defines.svh
//
// Usage:
//   Input channel carries one text character per word (char_code_i) and a
//   flag on the last character of a message (is_final_i). Output channel
//   carries one result per word: a decoded byte with status zero, or the
//   closing status of a message with message_end_o set. run_end_o marks the
//   last result caused by one input character.
//   The first result of a character shows in the cycle after it is
//   accepted. Characters are taken one per cycle, but one that causes results
//   may wait. Characters that cause no result pass while earlier results drain;
//   a character that causes results (a fourth one that completes a clean group,
//   or a final one) is taken once the output register is empty or its last
//   pending result leaves.
//   The output register sends one result per cycle while the receiver is
//   ready, at most four per word. If the receiver stalls, the pending result
//   holds and characters that cause results are refused while that register
//   is occupied. Reset clears the group state and empties the output register
//   at once; no clearing pass is needed and the block is ready after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "strict_base64_decoder_defines.svh"

module strict_base64_decoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       is_final_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [2:0]      status_o,
  output logic            run_end_o,
  output logic            message_end_o
);

  sb64_pkg::bundle_t bundle;
  logic              has_results;
  logic              space;
  logic              in_fire;
  logic [1:0]        quad;

  // words without results never need the output register
  assign in_ready_o = space || !has_results;
  assign in_fire    = in_valid_i && in_ready_o;

  // character decode and group state
  sb64_group u_group (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (in_fire),
    .char_code_i   (char_code_i),
    .is_final_i    (is_final_i),
    .bundle_o      (bundle),
    .has_results_o (has_results),
    .quad_o        (quad)
  );

  // result register and sequencing
  sb64_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (in_fire && has_results),
    .bundle_i      (bundle),
    .space_o       (space),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .status_o      (status_o),
    .run_end_o     (run_end_o),
    .message_end_o (message_end_o)
  );

  // no word with results while results of the previous word are still pending
  `SB64_ASSERT_IMPL(a_hold_input, clk_i, rst_ni,
                    out_valid_o && !(out_ready_i && run_end_o) && has_results, !in_ready_o)
  // a closing status is always the last result of its word and carries no byte
  `SB64_ASSERT_IMPL(a_status_shape, clk_i, rst_ni,
                    out_valid_o && message_end_o, run_end_o && out_byte_o == 8'h00)
  // a final character restarts the group
  `SB64_ASSERT_NEXT(a_restart, clk_i, rst_ni, in_fire && is_final_i, quad == 2'd0)
  // a final character always leaves a result pending
  `SB64_ASSERT_NEXT(a_final_result, clk_i, rst_ni, in_fire && is_final_i, out_valid_o)

endmodule

`default_nettype wire
